### rtl/rgbm_pkg.sv
package rgbm_pkg;

  // Defaults for the top level parameters
  localparam int unsigned LINE_WIDTH_DEF = 1280;
  localparam int unsigned PIXEL_BITS_DEF = 8;

  // Window geometry and selection rank
  localparam int unsigned WIN_SIDE    = 5;
  localparam int unsigned WIN_SIZE    = WIN_SIDE * WIN_SIDE;
  localparam int unsigned MEDIAN_RANK = (WIN_SIZE - 1) / 2;
  localparam int unsigned RANK_W      = $clog2(WIN_SIZE);

  // Line stores and colour channels
  localparam int unsigned STORE_LINES = WIN_SIDE - 1;
  localparam int unsigned LP_W        = $clog2(STORE_LINES);
  localparam int unsigned CHANNELS    = 3;
  localparam int unsigned CH_BITS     = 8;

endpackage

### rtl/rgbm_line_store.sv
module rgbm_line_store
  import rgbm_pkg::*;
#(
  parameter int unsigned LINE_WIDTH = LINE_WIDTH_DEF,
  parameter int unsigned PIXEL_BITS = PIXEL_BITS_DEF,
  localparam int unsigned COL_W  = $clog2(LINE_WIDTH),
  localparam int unsigned WORD_W = CHANNELS * PIXEL_BITS
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              access_i,
  input  logic [COL_W-1:0]  col_i,
  input  logic [LP_W-1:0]   line_i,
  input  logic [WORD_W-1:0] wdata_i,
  output logic [WORD_W-1:0] rdata_o [STORE_LINES],
  output logic              busy_o
);

  logic             busy_q, busy_d;
  logic [COL_W-1:0] clr_q, clr_d;

  // Clearing pass after reset: one column per cycle
  always_comb begin
    busy_d = busy_q;
    clr_d  = clr_q;
    if (busy_q) begin
      if (clr_q == COL_W'(LINE_WIDTH - 1)) begin
        busy_d = 1'b0;
      end else begin
        clr_d = clr_q + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
      clr_q  <= '0;
    end else begin
      busy_q <= busy_d;
      clr_q  <= clr_d;
    end
  end

  assign busy_o = busy_q;

  // One bank per stored line; read returns the old word on a same-edge write
  for (genvar b = 0; b < STORE_LINES; b++) begin : g_bank
    logic [WORD_W-1:0] mem [LINE_WIDTH];
    logic [WORD_W-1:0] rdata_q;

    always_ff @(posedge clk_i) begin
      if (busy_q) begin
        mem[clr_q] <= '0;
      end else if (access_i && (line_i == LP_W'(b))) begin
        mem[col_i] <= wdata_i;
      end
      if (access_i) begin
        rdata_q <= mem[col_i];
      end
    end

    assign rdata_o[b] = rdata_q;
  end

endmodule

### rtl/rgbm_median_lane.sv
module rgbm_median_lane
  import rgbm_pkg::*;
#(
  parameter int unsigned PIXEL_BITS = PIXEL_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 en_i,
  input  logic                                 shift_i,
  input  logic [WIN_SIDE-1:0][PIXEL_BITS-1:0] col_i,
  output logic [PIXEL_BITS-1:0]               med_o
);

  logic [PIXEL_BITS-1:0] win_q [WIN_SIZE];
  logic [WIN_SIZE-1:0]   prec_q [WIN_SIZE];
  logic [PIXEL_BITS-1:0] va_q [WIN_SIZE];
  logic [PIXEL_BITS-1:0] vb_q [WIN_SIZE];
  logic [RANK_W-1:0]     rank_q [WIN_SIZE];

  // Window: shift left, new column enters on the right
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < WIN_SIZE; i++) begin
        win_q[i] <= '0;
      end
    end else if (shift_i) begin
      for (int r = 0; r < WIN_SIDE; r++) begin
        for (int k = 1; k < WIN_SIDE; k++) begin
          win_q[r*WIN_SIDE + k - 1] <= win_q[r*WIN_SIDE + k];
        end
        win_q[r*WIN_SIDE + WIN_SIDE - 1] <= col_i[r];
      end
    end
  end

  // Pairwise order (ties broken by position), then rank of each element
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < WIN_SIZE; i++) begin
        for (int j = 0; j < WIN_SIZE; j++) begin
          if (j < i) begin
            prec_q[i][j] <= (win_q[j] <= win_q[i]);
          end else if (j > i) begin
            prec_q[i][j] <= (win_q[j] < win_q[i]);
          end else begin
            prec_q[i][j] <= 1'b0;
          end
        end
        va_q[i]   <= win_q[i];
        rank_q[i] <= RANK_W'($countones(prec_q[i]));
        vb_q[i]   <= va_q[i];
      end
    end
  end

  // Ranks form a permutation, so exactly one element matches
  always_comb begin
    med_o = '0;
    for (int i = 0; i < WIN_SIZE; i++) begin
      if (rank_q[i] == RANK_W'(MEDIAN_RANK)) begin
        med_o = med_o | vb_q[i];
      end
    end
  end

endmodule

### rtl/rgb_median_5x5_stream.sv
// Valid: accept passes through v1_q, v2_q, v3_q and v4_q into vo_q.
// Throughput: one pixel per cycle while in_stall_o is low; the line store banks
// are read and written in the same cycle as the transaction is accepted.
// Reset: window, column and line pointer clear at once; the line store is then
// cleared one column at a time, during which in_stall_o is held high.
module rgb_median_5x5_stream
  import rgbm_pkg::*;
#(
  parameter int unsigned LINE_WIDTH = LINE_WIDTH_DEF,
  parameter int unsigned PIXEL_BITS = PIXEL_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [CH_BITS-1:0] red_in_i,
  input  logic [CH_BITS-1:0] green_in_i,
  input  logic [CH_BITS-1:0] blue_in_i,
  input  logic               new_line_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [CH_BITS-1:0] red_median_o,
  output logic [CH_BITS-1:0] green_median_o,
  output logic [CH_BITS-1:0] blue_median_o
);

  localparam int unsigned COL_W  = $clog2(LINE_WIDTH);
  localparam int unsigned WORD_W = CHANNELS * PIXEL_BITS;

  logic               en, accept, busy;
  logic [COL_W-1:0]   col_q, col_d, col_eff;
  logic [LP_W-1:0]    lp_q, lp_eff;
  logic               v1_q, v2_q, v3_q, v4_q, vo_q;
  logic [WORD_W-1:0]  pix, pix_q;
  logic [WORD_W-1:0]  rdata [STORE_LINES];
  logic [PIXEL_BITS-1:0] med [CHANNELS];
  logic [CH_BITS-1:0] chan_in [CHANNELS];
  logic [CH_BITS-1:0] med_q [CHANNELS];

  // Pipeline advances unless the output register is held
  assign en         = !vo_q || !out_stall_i;
  assign in_stall_o = !en || busy;
  assign accept     = in_valid_i && !in_stall_o;

  // Pixel resized to the stored width
  assign chan_in[0] = red_in_i;
  assign chan_in[1] = green_in_i;
  assign chan_in[2] = blue_in_i;

  always_comb begin
    logic [PIXEL_BITS+CH_BITS-1:0] ext;
    for (int c = 0; c < CHANNELS; c++) begin
      ext = {{PIXEL_BITS{1'b0}}, chan_in[c]};
      pix[c*PIXEL_BITS +: PIXEL_BITS] = ext[PIXEL_BITS-1:0];
    end
  end

  // Column and line pointer for this transaction
  assign col_eff = new_line_i ? '0 : col_q;
  assign lp_eff  = new_line_i ? lp_q + LP_W'(1) : lp_q;
  assign col_d   = (col_eff == COL_W'(LINE_WIDTH - 1)) ? '0 : col_eff + COL_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      lp_q  <= '0;
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      v3_q  <= 1'b0;
      v4_q  <= 1'b0;
      vo_q  <= 1'b0;
    end else begin
      if (accept) begin
        col_q <= col_d;
        lp_q  <= lp_eff;
      end
      if (en) begin
        v1_q <= accept;
        v2_q <= v1_q;
        v3_q <= v2_q;
        v4_q <= v3_q;
        vo_q <= v4_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pix_q <= pix;
    end
  end

  rgbm_line_store #(
    .LINE_WIDTH (LINE_WIDTH),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_store (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .access_i (accept),
    .col_i    (col_eff),
    .line_i   (lp_eff),
    .wdata_i  (pix),
    .rdata_o  (rdata),
    .busy_o   (busy)
  );

  // One median lane per colour channel
  for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
    logic [WIN_SIDE-1:0][PIXEL_BITS-1:0] col;

    always_comb begin
      for (int r = 0; r < STORE_LINES; r++) begin
        col[r] = rdata[r][c*PIXEL_BITS +: PIXEL_BITS];
      end
      col[WIN_SIDE-1] = pix_q[c*PIXEL_BITS +: PIXEL_BITS];
    end

    rgbm_median_lane #(
      .PIXEL_BITS (PIXEL_BITS)
    ) u_lane (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .shift_i (v1_q && en),
      .col_i   (col),
      .med_o   (med[c])
    );
  end

  // Merge: output register collects the three lane results
  always_ff @(posedge clk_i) begin
    logic [PIXEL_BITS+CH_BITS-1:0] ext;
    if (en) begin
      for (int c = 0; c < CHANNELS; c++) begin
        ext      = {{CH_BITS{1'b0}}, med[c]};
        med_q[c] <= ext[CH_BITS-1:0];
      end
    end
  end

  assign out_valid_o    = vo_q;
  assign red_median_o   = med_q[0];
  assign green_median_o = med_q[1];
  assign blue_median_o  = med_q[2];

endmodule
